// ===== design/mtok_pkg.sv =====
package mtok_pkg;

    // element kinds on the result channel
    localparam logic [2:0] KIND_TEXT    = 3'd0;
    localparam logic [2:0] KIND_TAG     = 3'd1;
    localparam logic [2:0] KIND_COMMENT = 3'd2;
    localparam logic [2:0] KIND_SCRIPT  = 3'd3;
    localparam logic [2:0] KIND_ABORT   = 3'd4;

    // last token codes
    localparam logic [2:0] TOK_NONE    = 3'd0;
    localparam logic [2:0] TOK_TEXT    = 3'd1;
    localparam logic [2:0] TOK_TAG     = 3'd2;
    localparam logic [2:0] TOK_COMMENT = 3'd3;
    localparam logic [2:0] TOK_SCRIPT  = 3'd4;

    // byte codes
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_QUEST = 8'h3f;
    localparam logic [7:0] CH_PCT   = 8'h25;

    localparam logic [2:0] HIST_FULL = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } item_t;

    typedef struct packed {
        logic [2:0]  element_kind;
        logic [15:0] element_row;
        logic [15:0] element_col;
        logic [15:0] element_length;
        logic        includes_current;
        logic [15:0] element_count;
    } res_t;

endpackage

// ===== design/markup_element_tokenizer.sv =====
// Markup element tokenizer. Takes one byte word per clock unless in_stall is
// raised and reports text, tag, comment and script elements (kind, start
// row/column, length, and a running count of text and tag elements); a '<'
// inside an open tag gives an abort word and all later bytes are ignored until
// a word with restart set. A byte passes through an input register, parse
// logic that updates the state registers, and a result register; a byte can
// be taken every cycle while in_stall is low; bytes that produce no element
// use a slot but give no output word. out_stall holds the result register
// and, once the input register is also occupied, raises in_stall. Internal
// counters are COUNTER_WIDTH bits and saturate; reported fields clip at
// 65535. remove_crlf (cfg_wdata under cfg_write_en) drops CR and LF bytes;
// write it only while the block is idle.
module markup_element_tokenizer
    import mtok_pkg::*;
#(
    parameter int COUNTER_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  element_kind,
    output logic [15:0] element_row,
    output logic [15:0] element_col,
    output logic [15:0] element_length,
    output logic        includes_current,
    output logic [15:0] element_count
);

    item_t in_item, item;
    logic  item_valid;
    logic  res_take;
    logic  fire;
    logic  res_valid;
    res_t  res, out_res;

    assign in_item.data_byte = data_byte;
    assign in_item.restart   = restart;

    // a held byte is parsed whenever the result register has room
    assign fire = item_valid && res_take;

    mtok_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (res_take)
    );

    mtok_step #(
        .CW (COUNTER_WIDTH)
    ) u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_wdata    (cfg_wdata),
        .fire         (fire),
        .item         (item),
        .res_valid    (res_valid),
        .res          (res)
    );

    mtok_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign element_kind     = out_res.element_kind;
    assign element_row      = out_res.element_row;
    assign element_col      = out_res.element_col;
    assign element_length   = out_res.element_length;
    assign includes_current = out_res.includes_current;
    assign element_count    = out_res.element_count;

endmodule

// ===== design/mtok_in_reg.sv =====
module mtok_in_reg
    import mtok_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  item_t in_item,
    output logic  item_valid,
    output item_t item,
    input  logic  item_take
);

    logic  valid_reg;
    item_t item_reg;

    // hold while the word in the register cannot move on
    assign in_stall   = valid_reg && !item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== design/mtok_step.sv =====
module mtok_step
    import mtok_pkg::*;
#(
    parameter int CW = 16
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_write_en,
    input  logic  cfg_wdata,
    input  logic  fire,
    input  item_t item,
    output logic  res_valid,
    output res_t  res
);

    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    logic          crlf_reg;
    logic [31:0]   hist_reg,  hist_next;
    logic [2:0]    fill_reg,  fill_next;
    logic          cap_reg,   cap_next;
    logic [2:0]    last_reg,  last_next;
    logic [CW-1:0] row_reg,   row_next;
    logic [CW-1:0] col_reg,   col_next;
    logic [CW-1:0] srow_reg,  srow_next;
    logic [CW-1:0] scol_reg,  scol_next;
    logic [CW-1:0] trow_reg,  trow_next;
    logic [CW-1:0] tcol_reg,  tcol_next;
    logic [CW-1:0] pend_reg,  pend_next;
    logic [CW-1:0] seen_reg,  seen_next;
    logic          abort_reg, abort_next;

    logic [7:0]    b;
    logic          drop, full, done, emit;
    logic          com_start, com_end, scr_start, scr_end;
    logic [15:0]   h16;
    logic [2:0]    kind;
    logic [CW-1:0] e_row, e_col, e_len;
    logic          e_incl;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_ONE;
    endfunction

    function automatic logic [15:0] clip(input logic [CW-1:0] v);
        return (CW > 16 && (v >> 16) != '0) ? 16'hffff : 16'(v);
    endfunction

    assign b = item.data_byte;

    always_comb
    begin
        // restart clears parse state before the byte is looked at
        if (item.restart)
        begin
            hist_next  = '0;
            fill_next  = '0;
            cap_next   = 1'b0;
            last_next  = TOK_NONE;
            row_next   = CNT_ONE;
            col_next   = CNT_ONE;
            srow_next  = CNT_ONE;
            scol_next  = CNT_ONE;
            trow_next  = CNT_ONE;
            tcol_next  = CNT_ONE;
            pend_next  = '0;
            seen_next  = '0;
            abort_next = 1'b0;
        end
        else
        begin
            hist_next  = hist_reg;
            fill_next  = fill_reg;
            cap_next   = cap_reg;
            last_next  = last_reg;
            row_next   = row_reg;
            col_next   = col_reg;
            srow_next  = srow_reg;
            scol_next  = scol_reg;
            trow_next  = trow_reg;
            tcol_next  = tcol_reg;
            pend_next  = pend_reg;
            seen_next  = seen_reg;
            abort_next = abort_reg;
        end

        emit      = 1'b0;
        done      = 1'b0;
        kind      = KIND_TEXT;
        e_row     = '0;
        e_col     = '0;
        e_len     = '0;
        e_incl    = 1'b0;
        full      = 1'b0;
        h16       = '0;
        com_start = 1'b0;
        com_end   = 1'b0;
        scr_start = 1'b0;
        scr_end   = 1'b0;

        drop = abort_next || (crlf_reg && (b == CH_CR || b == CH_LF));

        if (!drop)
        begin
            col_next = sat_inc(col_next);
            if (b == CH_CR)
            begin
                col_next = '0;
                row_next = sat_inc(row_next);
            end
            hist_next = {hist_next[23:0], b};
            if (fill_next < HIST_FULL)
            begin
                fill_next = fill_next + 3'd1;
            end

            full      = (fill_next == HIST_FULL);
            h16       = hist_next[15:0];
            com_start = full && hist_next == {CH_LT, CH_BANG, CH_DASH, CH_DASH};
            com_end   = full && hist_next[23:0] == {CH_DASH, CH_DASH, CH_GT};
            scr_start = full && (h16 == {CH_LT, CH_QUEST} || h16 == {CH_LT, CH_PCT});
            scr_end   = full && (h16 == {CH_QUEST, CH_GT} || h16 == {CH_PCT, CH_GT});

            if (com_start)
            begin
                cap_next  = 1'b0;
                last_next = TOK_COMMENT;
                srow_next = row_next;
                scol_next = (col_next >= CW'(3)) ? col_next - CW'(3) : '0;
            end
            if (com_end)
            begin
                emit      = 1'b1;
                done      = 1'b1;
                kind      = KIND_COMMENT;
                e_row     = srow_next;
                e_col     = scol_next;
                e_len     = sat_inc(pend_next);
                e_incl    = 1'b1;
                pend_next = '0;
                last_next = TOK_NONE;
            end
            if (!done && scr_start)
            begin
                cap_next  = 1'b0;
                last_next = TOK_SCRIPT;
                srow_next = row_next;
                scol_next = (col_next >= CNT_ONE) ? col_next - CNT_ONE : '0;
            end
            if (!done && scr_end)
            begin
                emit      = 1'b1;
                done      = 1'b1;
                kind      = KIND_SCRIPT;
                e_row     = srow_next;
                e_col     = scol_next;
                e_len     = sat_inc(pend_next);
                e_incl    = 1'b1;
                pend_next = '0;
                last_next = TOK_NONE;
            end
            // inside a comment everything is content
            if (!done && last_next == TOK_COMMENT)
            begin
                pend_next = sat_inc(pend_next);
                done      = 1'b1;
            end

            if (!done)
            begin
                if (b == CH_LT)
                begin
                    emit   = 1'b1;
                    if (!cap_next)
                    begin
                        kind      = KIND_TEXT;
                        e_row     = trow_next;
                        e_col     = tcol_next;
                        e_len     = pend_next;
                        e_incl    = 1'b0;
                        last_next = TOK_TEXT;
                        pend_next = CNT_ONE;
                        cap_next  = 1'b1;
                        srow_next = row_next;
                        scol_next = col_next;
                        seen_next = sat_inc(seen_next);
                    end
                    else
                    begin
                        // nested open: stop until restart
                        pend_next  = sat_inc(pend_next);
                        abort_next = 1'b1;
                        kind       = KIND_ABORT;
                        e_row      = row_next;
                        e_col      = col_next;
                        e_len      = pend_next;
                        e_incl     = 1'b1;
                    end
                end
                else if (b == CH_GT && cap_next)
                begin
                    emit      = 1'b1;
                    kind      = KIND_TAG;
                    e_row     = srow_next;
                    e_col     = scol_next;
                    e_len     = sat_inc(pend_next);
                    e_incl    = 1'b1;
                    pend_next = '0;
                    cap_next  = 1'b0;
                    last_next = TOK_TAG;
                    trow_next = row_next;
                    tcol_next = sat_inc(col_next);
                    seen_next = sat_inc(seen_next);
                end
                else
                begin
                    pend_next = sat_inc(pend_next);
                    last_next = TOK_NONE;
                end
            end
        end
    end

    assign res_valid            = fire && emit;
    assign res.element_kind     = kind;
    assign res.element_row      = clip(e_row);
    assign res.element_col      = clip(e_col);
    assign res.element_length   = clip(e_len);
    assign res.includes_current = e_incl;
    assign res.element_count    = clip(seen_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crlf_reg  <= 1'b0;
            hist_reg  <= '0;
            fill_reg  <= '0;
            cap_reg   <= 1'b0;
            last_reg  <= TOK_NONE;
            row_reg   <= CNT_ONE;
            col_reg   <= CNT_ONE;
            srow_reg  <= CNT_ONE;
            scol_reg  <= CNT_ONE;
            trow_reg  <= CNT_ONE;
            tcol_reg  <= CNT_ONE;
            pend_reg  <= '0;
            seen_reg  <= '0;
            abort_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                crlf_reg <= cfg_wdata;
            end
            if (fire)
            begin
                hist_reg  <= hist_next;
                fill_reg  <= fill_next;
                cap_reg   <= cap_next;
                last_reg  <= last_next;
                row_reg   <= row_next;
                col_reg   <= col_next;
                srow_reg  <= srow_next;
                scol_reg  <= scol_next;
                trow_reg  <= trow_next;
                tcol_reg  <= tcol_next;
                pend_reg  <= pend_next;
                seen_reg  <= seen_next;
                abort_reg <= abort_next;
            end
        end
    end

endmodule

// ===== design/mtok_out_reg.sv =====
module mtok_out_reg
    import mtok_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic res_valid,
    input  res_t res,
    output logic res_take,
    output logic out_valid,
    input  logic out_stall,
    output res_t out_res
);

    logic valid_reg;
    res_t res_reg;

    // room when empty or when the held word leaves this edge
    assign res_take  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule
